/* hdl/qease_pkg.sv */
// ----------------------------------------------------------------------------
// qease_pkg
// Shared types and float helpers for the quadratic ease datapath: operand
// read, exact-product multiply with chop, and the magnitude subtract unit
// that rounds to double width before the chop to single.
// ----------------------------------------------------------------------------
package qease_pkg;

    localparam logic [30:0] MAG_MAX  = 31'h7f7fffff;
    localparam logic [31:0] ONE_BITS = 32'h3f800000;
    localparam logic [30:0] HALF_MAG = 31'h3f000000;
    localparam logic [7:0]  EXP_ALL  = 8'hff;
    localparam logic [7:0]  EXP_TOP  = 8'hfe;
    localparam logic [5:0]  DX_BITS  = 6'd57;

    // aligned difference of two magnitudes, sticky bit in the lsb
    typedef struct packed {
        logic        sign;
        logic [7:0]  el;
        logic [56:0] dx;
    } diff_t;

    // raw product before exponent fix-up and chop
    typedef struct packed {
        logic              sign;
        logic              zero;
        logic signed [9:0] exp;
        logic [47:0]       p;
    } prod_t;

    function automatic logic [31:0] read_op(input logic [31:0] a);
        logic [31:0] r;
        r = a;
        if (a[30:23] == 8'h00)
            r = {a[31], 31'h0};
        else if (a[30:23] == EXP_ALL)
            r = {a[31], MAG_MAX};
        return r;
    endfunction

    function automatic logic [31:0] mul_two(input logic [31:0] a);
        logic [31:0] r;
        r = a;
        if (a[30:23] == EXP_TOP)
            r = {a[31], MAG_MAX};
        else if (a[30:23] != 8'h00)
            r = {a[31], a[30:23] + 8'd1, a[22:0]};
        return r;
    endfunction

    function automatic logic [31:0] mul_half(input logic [31:0] a);
        logic [31:0] r;
        if (a[30:23] <= 8'd1)
            r = {a[31], 31'h0};
        else
            r = {a[31], a[30:23] - 8'd1, a[22:0]};
        return r;
    endfunction

    function automatic prod_t mul_raw(input logic [31:0] a, input logic [31:0] b);
        prod_t r;
        r.sign = a[31] ^ b[31];
        r.zero = (a[30:23] == 8'h00) || (b[30:23] == 8'h00);
        r.exp  = signed'({2'b00, a[30:23]}) + signed'({2'b00, b[30:23]}) - 10'sd127;
        r.p    = 48'({1'b1, a[22:0]}) * 48'({1'b1, b[22:0]});
        return r;
    endfunction

    function automatic logic [31:0] mul_fin(input prod_t q);
        logic signed [9:0] e;
        logic [22:0]       f;
        logic [31:0]       r;
        e = q.exp + signed'({9'h0, q.p[47]});
        f = q.p[47] ? q.p[46:24] : q.p[45:23];
        if (q.zero || e <= 10'sd0)
            r = {q.sign, 31'h0};
        else if (e >= 10'sd255)
            r = {q.sign, MAG_MAX};
        else
            r = {q.sign, e[7:0], f};
        return r;
    endfunction

    // a - b on magnitudes, both operands non-negative
    function automatic diff_t sub_align(input logic [31:0] a, input logic [31:0] b);
        logic [30:0] big;
        logic [30:0] lit;
        logic [23:0] ml;
        logic [23:0] ms;
        logic [7:0]  dif;
        logic [55:0] sfield;
        logic [55:0] sshift;
        logic [55:0] lost;
        logic        stk;
        diff_t       r;
        r.sign = a[30:0] < b[30:0];
        big    = r.sign ? b[30:0] : a[30:0];
        lit    = r.sign ? a[30:0] : b[30:0];
        ml     = (big[30:23] == 8'h00) ? 24'h0 : {1'b1, big[22:0]};
        ms     = (lit[30:23] == 8'h00) ? 24'h0 : {1'b1, lit[22:0]};
        dif    = big[30:23] - lit[30:23];
        sfield = {ms, 32'h0};
        lost   = '0;
        if (dif >= 8'd56)
        begin
            sshift = '0;
            stk    = |ms;
        end
        else
        begin
            sshift = sfield >> dif;
            lost   = sfield & ((56'd1 << dif) - 56'd1);
            stk    = |lost;
        end
        r.el = big[30:23];
        r.dx = {ml, 33'h0} - {sshift, stk};
        return r;
    endfunction

    function automatic logic [5:0] lzc57(input logic [56:0] dx);
        logic [5:0] n;
        n = DX_BITS;
        for (int i = 0; i < 57; i++)
        begin
            if (dx[i])
                n = 6'(56 - i);
        end
        return n;
    endfunction

    // round to 53 bits nearest-even, then chop to 24 and flush
    function automatic logic [31:0] sub_fin(input diff_t q, input logic [5:0] lz);
        logic [56:0]       n;
        logic              up;
        logic              carry;
        logic [24:0]       m;
        logic signed [9:0] e;
        logic [31:0]       r;
        n     = q.dx << lz;
        up    = n[3] & (n[4] | (|n[2:0]));
        carry = up & (&n[32:4]);
        m     = {1'b0, n[56:33]} + {24'h0, carry};
        e     = signed'({2'b00, q.el}) - signed'({4'h0, lz}) + signed'({9'h0, m[24]});
        if (q.dx == 57'h0)
            r = 32'h0;
        else if (e <= 10'sd0)
            r = {q.sign, 31'h0};
        else
            r = {q.sign, e[7:0], m[22:0]};
        return r;
    endfunction

endpackage

/* hdl/quadratic_ease_chop_fpu.sv */
// ----------------------------------------------------------------------------
// quadratic_ease_chop_fpu
// Quadratic ease-in-out weight on single-precision patterns with
// flush-to-zero operands, saturation and chop rounding.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  x_bits / x_valid / x_ready carries one position pattern
//   output channel weight_bits / weight_valid / weight_ready returns its
//   weight, one result per input, in input order.
//   The datapath is a seven-stage pipeline: subtract align, leading-zero
//   count, normalize and round, scale and multiply, chop and second
//   subtract align, leading-zero count, final round and select.
//   One item can be taken every cycle unless every stage holds an item
//   and weight_ready is low.
//   Each stage has its own valid bit and moves whenever it is empty or the
//   stage after it moves, so bubbles close up while the receiver stalls;
//   x_ready drops only once every stage holds an item.
//   Reset clears all valid bits; no item is in flight after reset.
// ----------------------------------------------------------------------------
module quadratic_ease_chop_fpu
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] x_bits,
    input  logic        x_valid,
    output logic        x_ready,
    output logic [31:0] weight_bits,
    output logic        weight_valid,
    input  logic        weight_ready
);

    typedef struct packed {
        logic                hi;
        logic [31:0]         xr;
        logic [31:0]         t;
        qease_pkg::diff_t    dif;
    } st1_t;

    typedef struct packed {
        logic                hi;
        qease_pkg::diff_t    dif;
        logic [5:0]          lz;
        qease_pkg::prod_t    pa;
    } st2_t;

    typedef struct packed {
        logic                hi;
        logic [31:0]         s;
        logic [31:0]         ra;
    } st3_t;

    typedef struct packed {
        logic                hi;
        logic [31:0]         ra;
        qease_pkg::prod_t    pf;
    } st4_t;

    typedef struct packed {
        logic                hi;
        logic [31:0]         ra;
        qease_pkg::diff_t    dif;
    } st5_t;

    typedef struct packed {
        logic                hi;
        logic [31:0]         ra;
        qease_pkg::diff_t    dif;
        logic [5:0]          lz;
    } st6_t;

    logic [6:0]  vld_reg;
    logic [6:0]  vld_next;
    logic [6:0]  en;
    st1_t        st1_reg, st1_next;
    st2_t        st2_reg, st2_next;
    st3_t        st3_reg, st3_next;
    st4_t        st4_reg, st4_next;
    st5_t        st5_reg, st5_next;
    st6_t        st6_reg, st6_next;
    logic [31:0] weight_reg, weight_next;
    logic [31:0] d_val;
    logic [31:0] e_val;

    // stall chain: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[6] = ~vld_reg[6] | weight_ready;
        for (int k = 5; k >= 0; k--)
            en[k] = ~vld_reg[k] | en[k + 1];
        vld_next[0] = en[0] ? x_valid : vld_reg[0];
        for (int k = 1; k < 7; k++)
            vld_next[k] = en[k] ? vld_reg[k - 1] : vld_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    always_comb
    begin
        st1_next.xr  = qease_pkg::read_op(x_bits);
        st1_next.hi  = ~st1_next.xr[31] && (st1_next.xr[30:0] > qease_pkg::HALF_MAG);
        st1_next.t   = qease_pkg::mul_two(st1_next.xr);
        st1_next.dif = qease_pkg::sub_align(st1_next.xr, qease_pkg::ONE_BITS);

        st2_next.hi  = st1_reg.hi;
        st2_next.dif = st1_reg.dif;
        st2_next.lz  = qease_pkg::lzc57(st1_reg.dif.dx);
        st2_next.pa  = qease_pkg::mul_raw(st1_reg.t, st1_reg.xr);

        st3_next.hi  = st2_reg.hi;
        st3_next.s   = qease_pkg::sub_fin(st2_reg.dif, st2_reg.lz);
        st3_next.ra  = qease_pkg::mul_fin(st2_reg.pa);

        d_val        = qease_pkg::mul_two(st3_reg.s);
        e_val        = qease_pkg::mul_half(d_val);
        st4_next.hi  = st3_reg.hi;
        st4_next.ra  = st3_reg.ra;
        st4_next.pf  = qease_pkg::mul_raw(e_val, d_val);

        st5_next.hi  = st4_reg.hi;
        st5_next.ra  = st4_reg.ra;
        st5_next.dif = qease_pkg::sub_align(qease_pkg::ONE_BITS,
                                            qease_pkg::mul_fin(st4_reg.pf));

        st6_next.hi  = st5_reg.hi;
        st6_next.ra  = st5_reg.ra;
        st6_next.dif = st5_reg.dif;
        st6_next.lz  = qease_pkg::lzc57(st5_reg.dif.dx);

        weight_next  = st6_reg.hi ? qease_pkg::sub_fin(st6_reg.dif, st6_reg.lz)
                                  : st6_reg.ra;
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (en[0])
            st1_reg <= st1_next;
        if (en[1])
            st2_reg <= st2_next;
        if (en[2])
            st3_reg <= st3_next;
        if (en[3])
            st4_reg <= st4_next;
        if (en[4])
            st5_reg <= st5_next;
        if (en[5])
            st6_reg <= st6_next;
        if (en[6])
            weight_reg <= weight_next;
    end

    assign x_ready      = en[0];
    assign weight_valid = vld_reg[6];
    assign weight_bits  = weight_reg;

endmodule

/* hdl/qease_chk.sv */
// ----------------------------------------------------------------------------
// qease_chk
// Port-level checks for the quadratic ease pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module qease_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        x_ready,
    input logic        weight_valid,
    input logic        weight_ready,
    input logic [31:0] weight_bits
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        weight_valid && !weight_ready |=> weight_valid)
        else $error("weight_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        weight_valid && !weight_ready |=> $stable(weight_bits))
        else $error("weight_bits changed while stalled");

    // a taken result frees the whole pipe
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        weight_ready |-> x_ready)
        else $error("x_ready low although output drains");

    a_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !weight_valid)
        else $error("result offered right after reset");

    // results are never inf, nan or denormal
    a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        weight_valid |-> (weight_bits[30:23] != 8'hff) &&
                         ((weight_bits[30:23] != 8'h00) || (weight_bits[22:0] == 23'h0)))
        else $error("weight_bits not a flushed, saturated pattern");

endmodule

bind quadratic_ease_chop_fpu qease_chk u_qease_chk
(
    .clk          (clk),
    .rst_n        (rst_n),
    .x_ready      (x_ready),
    .weight_valid (weight_valid),
    .weight_ready (weight_ready),
    .weight_bits  (weight_bits)
);

/* test/quadratic_ease_chop_fpu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_ease_chop_fpu_checker
// Watches both channels of the ease block, computes the expected weight for
// every accepted position and compares it with each returned weight in order.
// ----------------------------------------------------------------------------
module quadratic_ease_chop_fpu_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] x_bits,
    input  logic        x_valid,
    input  logic        x_ready,
    input  logic [31:0] weight_bits,
    input  logic        weight_valid,
    input  logic        weight_ready,
    output int          errors,
    output int          pending
);

    localparam logic [31:0] TWO_F  = 32'h40000000;
    localparam logic [31:0] ONE_F  = 32'h3f800000;
    localparam logic [31:0] HALF_F = 32'h3f000000;
    localparam logic [30:0] MAX_F  = 31'h7f7fffff;
    localparam real         MAX_D  = 3.40282346638528860e+38;

    logic [31:0] weights_due[$];

    // flush denormals, clamp inf and nan to signed max
    function automatic logic [31:0] fpu_read(input logic [31:0] b);
        if (b[30:23] == 8'h00)
            return {b[31], 31'h0};
        if (b[30:23] == 8'hff)
            return {b[31], MAX_F};
        return b;
    endfunction

    function automatic real to_real(input logic [31:0] b);
        logic [10:0] e;
        if (b[30:23] == 8'h00)
            return $bitstoreal({b[31], 63'h0});
        e = {3'b000, b[30:23]} + 11'd896;
        return $bitstoreal({b[31], e, b[22:0], 29'h0});
    endfunction

    // saturate, truncate toward zero, flush small results
    function automatic logic [31:0] fpu_write(input real d);
        logic [63:0] q;
        int          e;
        if (d > MAX_D)
            return {1'b0, MAX_F};
        if (d < -MAX_D)
            return {1'b1, MAX_F};
        q = $realtobits(d);
        e = int'(q[62:52]) - 896;
        if (e <= 0)
            return {q[63], 31'h0};
        return {q[63], 8'(e), q[51:29]};
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        return fpu_write(to_real(fpu_read(a)) * to_real(fpu_read(b)));
    endfunction

    function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
        return fpu_write(to_real(fpu_read(a)) - to_real(fpu_read(b)));
    endfunction

    function automatic logic [31:0] ease_weight(input logic [31:0] x);
        logic [31:0] d;
        if (to_real(fpu_read(x)) <= 0.5)
            return fmul(fmul(TWO_F, x), x);
        d = fmul(TWO_F, fsub(x, ONE_F));
        return fsub(ONE_F, fmul(fmul(HALF_F, d), d));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors  = 0;
            weights_due.delete();
            pending = 0;
        end
        else
        begin
            if (x_valid && x_ready)
                weights_due.push_back(ease_weight(x_bits));
            if (weight_valid && weight_ready)
            begin
                if (weights_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected weight %h", weight_bits);
                end
                else
                begin
                    logic [31:0] want;
                    want = weights_due.pop_front();
                    if (want !== weight_bits)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("weight mismatch: expected %h got %h", want, weight_bits);
                    end
                end
            end
            pending = weights_due.size();
        end
    end

endmodule

/* test/quadratic_ease_chop_fpu_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadratic_ease_chop_fpu_tb
// Drives directed and random position patterns into the ease block with
// random gaps and back-pressure, one long receiver hold-off included; the
// checker predicts each weight and the top gives the verdict.
// ----------------------------------------------------------------------------
module quadratic_ease_chop_fpu_tb;

    logic        clk;
    logic        rst_n;
    logic [31:0] x_bits;
    logic        x_valid;
    logic        x_ready;
    logic [31:0] weight_bits;
    logic        weight_valid;
    logic        weight_ready;
    logic        hold_req;
    int          errors;
    int          pending;

    localparam logic [31:0] CORNER_X[22] = '{
        32'h00000000, 32'h80000000, 32'h3f000000, 32'h3f000001, 32'h3effffff,
        32'h3f800000, 32'h3f7fffff, 32'h7f800000, 32'hff800000, 32'h7fc00000,
        32'hffffffff, 32'h00000001, 32'h80000001, 32'h7f7fffff, 32'hff7fffff,
        32'h3e800000, 32'h3f400000, 32'h40000000, 32'hbf800000, 32'h60ad78ec,
        32'h00800000, 32'h1f800000
    };

    quadratic_ease_chop_fpu u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_bits       (x_bits),
        .x_valid      (x_valid),
        .x_ready      (x_ready),
        .weight_bits  (weight_bits),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready)
    );

    quadratic_ease_chop_fpu_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_bits       (x_bits),
        .x_valid      (x_valid),
        .x_ready      (x_ready),
        .weight_bits  (weight_bits),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready),
        .errors       (errors),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #1600000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // mostly positions near the eased range, the rest raw patterns
    function automatic logic [31:0] random_x();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(0, 9) < 6)
        begin
            v[31]    = ($urandom_range(0, 15) == 0);
            v[30:23] = 8'($urandom_range(8'h70, 8'h7f));
        end
        return v;
    endfunction

    task automatic send_x(input logic [31:0] v);
        int gap;
        x_bits  = v;
        x_valid = 1'b1;
        do
            @(posedge clk);
        while (!x_ready);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            x_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // receiver side stalls
    initial
    begin
        int   len;
        logic hold_done;
        weight_ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                weight_ready = 1'b0;
                repeat (80) @(negedge clk);
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                weight_ready = 1'b1;
            end
            else
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 3);
                weight_ready = 1'b0;
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        x_bits   = '0;
        x_valid  = 1'b0;
        hold_req = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (CORNER_X[i])
            send_x(CORNER_X[i]);
        for (int n = 0; n < 900; n++)
        begin
            if (n == 300)
                hold_req = 1'b1;
            send_x(random_x());
        end
        x_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
